[src/mnee_pkg.sv]
`timescale 1ns / 1ps

package mnee_pkg;

    // field widths
    localparam int DUR_W   = 32;
    localparam int VLQ_W   = 28;
    localparam int CHAN_W  = 4;
    localparam int DATA7_W = 7;
    localparam int STEP_W  = 4;

    // status nibbles
    localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
    localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;

    // byte positions within one event
    localparam logic [STEP_W-1:0] STEP_DELTA   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_ON      = 4'd1;
    localparam logic [STEP_W-1:0] STEP_ON_KEY  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_ON_VEL  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_DUR0    = 4'd4;
    localparam logic [STEP_W-1:0] STEP_DUR1    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_DUR2    = 4'd6;
    localparam logic [STEP_W-1:0] STEP_DUR3    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_OFF     = 4'd8;
    localparam logic [STEP_W-1:0] STEP_OFF_KEY = 4'd9;
    localparam logic [STEP_W-1:0] STEP_OFF_VEL = 4'd10;

    // one captured note event, duration already saturated and sized
    typedef struct packed {
        logic [VLQ_W-1:0]   dur;
        logic [1:0]         groups_m1;
        logic [CHAN_W-1:0]  chan;
        logic [DATA7_W-1:0] key;
        logic [DATA7_W-1:0] vel;
    } event_t;

endpackage

[src/midi_note_event_encoder_unit.sv]
`timescale 1ns / 1ps
// channel  | direction | handshake             | payload
// input    | in        | in_valid / in_ready   | duration_ticks, channel, note_key, note_velocity
// output   | out       | out_valid / out_ready | out_byte, last_byte
//
// each item yields 8 to 11 bytes (4 + 1..4 duration + 3), one per cycle unless
// out_ready stalls; an item occupies the event register until its last byte is loaded
// the next item is taken in the cycle its predecessor's last byte is loaded
// after acceptance, the first byte passes from the event register into the result register
// reset clears the valid flags and the byte position
// out_ready low holds the result register and, behind it, the event register

module midi_note_event_encoder_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [mnee_pkg::DUR_W-1:0]   duration_ticks,
    input  logic [mnee_pkg::CHAN_W-1:0]  channel,
    input  logic [mnee_pkg::DATA7_W-1:0] note_key,
    input  logic [mnee_pkg::DATA7_W-1:0] note_velocity,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   out_byte,
    output logic                         last_byte
);
    import mnee_pkg::*;

    logic   ev_valid;
    logic   ev_pop;
    event_t ev;

    // input register with saturation and group count
    mnee_event_reg u_event_reg (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .duration_ticks (duration_ticks),
        .channel        (channel),
        .note_key       (note_key),
        .note_velocity  (note_velocity),
        .ev_pop         (ev_pop),
        .ev_valid       (ev_valid),
        .ev             (ev)
    );

    // byte sequencer and result register
    mnee_byte_seq u_byte_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .ev_valid  (ev_valid),
        .ev        (ev),
        .ev_pop    (ev_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last_byte (last_byte)
    );

endmodule

[src/mnee_event_reg.sv]
`timescale 1ns / 1ps

module mnee_event_reg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [mnee_pkg::DUR_W-1:0]     duration_ticks,
    input  logic [mnee_pkg::CHAN_W-1:0]    channel,
    input  logic [mnee_pkg::DATA7_W-1:0]   note_key,
    input  logic [mnee_pkg::DATA7_W-1:0]   note_velocity,
    input  logic                           ev_pop,
    output logic                           ev_valid,
    output mnee_pkg::event_t               ev
);
    import mnee_pkg::*;

    logic             valid_reg;
    event_t           ev_reg;
    event_t           ev_next;
    logic [VLQ_W-1:0] sat_dur;

    // accept when empty or when the held event sends its last byte now
    assign in_ready = !valid_reg || ev_pop;
    assign ev_valid = valid_reg;
    assign ev       = ev_reg;

    // saturate duration and count its 7-bit groups
    always_comb
    begin
        sat_dur = (|duration_ticks[DUR_W-1:VLQ_W]) ? {VLQ_W{1'b1}}
                                                   : duration_ticks[VLQ_W-1:0];
        ev_next.dur  = sat_dur;
        ev_next.chan = channel;
        ev_next.key  = note_key;
        ev_next.vel  = note_velocity;
        priority if (|sat_dur[27:21])
        begin
            ev_next.groups_m1 = 2'd3;
        end
        else if (|sat_dur[20:14])
        begin
            ev_next.groups_m1 = 2'd2;
        end
        else if (|sat_dur[13:7])
        begin
            ev_next.groups_m1 = 2'd1;
        end
        else
        begin
            ev_next.groups_m1 = 2'd0;
        end
    end

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // event payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ev_reg <= ev_next;
        end
    end

endmodule

[src/mnee_byte_seq.sv]
`timescale 1ns / 1ps

module mnee_byte_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             ev_valid,
    input  mnee_pkg::event_t ev,
    output logic             ev_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic             last_byte
);
    import mnee_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic [7:0]        byte_reg;
    logic              last_reg;
    logic [7:0]        byte_next;
    logic              load;
    logic [1:0]        grp;
    logic              dur_done;

    assign out_valid = out_valid_reg;
    assign out_byte  = byte_reg;
    assign last_byte = last_reg;

    // output register free or draining this cycle
    assign load   = ev_valid && (!out_valid_reg || out_ready);
    assign ev_pop = load && (step_reg == STEP_OFF_VEL);

    // duration groups go most significant first
    assign grp      = ev.groups_m1 - step_reg[1:0];
    assign dur_done = (step_reg[1:0] == ev.groups_m1);

    // byte for the current position
    always_comb
    begin
        unique case (step_reg)
            STEP_DELTA:   byte_next = 8'h00;
            STEP_ON:      byte_next = {STATUS_NOTE_ON, ev.chan};
            STEP_ON_KEY:  byte_next = {1'b0, ev.key};
            STEP_ON_VEL:  byte_next = {1'b0, ev.vel};
            STEP_DUR0, STEP_DUR1, STEP_DUR2, STEP_DUR3:
                byte_next = {(grp != 2'd0), ev.dur[7*grp +: 7]};
            STEP_OFF:     byte_next = {STATUS_NOTE_OFF, ev.chan};
            STEP_OFF_KEY: byte_next = {1'b0, ev.key};
            STEP_OFF_VEL: byte_next = {1'b0, ev.vel};
            default:      byte_next = 8'h00;
        endcase
    end

    // next position, skipping unused duration slots
    always_comb
    begin
        priority if (step_reg == STEP_OFF_VEL)
        begin
            step_next = STEP_DELTA;
        end
        else if (step_reg >= STEP_DUR0 && step_reg <= STEP_DUR3 && dur_done)
        begin
            step_next = STEP_OFF;
        end
        else
        begin
            step_next = step_reg + 4'd1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_DELTA;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                step_reg <= step_next;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= byte_next;
            last_reg <= (step_reg == STEP_OFF_VEL);
        end
    end

endmodule

[src/mnee_checker.sv]
`timescale 1ns / 1ps

module mnee_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       last_byte
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_byte))
        else $error("stalled result changed");

    // bytes of one event follow without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_byte |=> out_valid)
        else $error("gap inside an event");

    // closing byte is a velocity, never a status or continuation byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_byte |-> !out_byte[7])
        else $error("last byte has bit 7 set");

    // nothing comes out right after reset
    assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid after reset");

endmodule

bind midi_note_event_encoder_unit mnee_checker u_mnee_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last_byte (last_byte)
);

[tb/sv/midi_note_event_encoder_unit_tb.sv]
`timescale 1ns / 1ps

module midi_note_event_encoder_unit_tb;

    import mnee_pkg::*;

    localparam int                 LIMIT_CYCLES = 200000;
    localparam int                 TAIL_CYCLES  = 16;
    localparam int                 HOLD_CYCLES  = 400;
    localparam logic [DUR_W-1:0]   VLQ_CEILING  = 32'h0FFF_FFFF;
    localparam logic [7:0]         DELTA_ZERO   = 8'h00;

    // one encoded byte as the block should send it
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } midi_byte_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [DUR_W-1:0]    duration_ticks;
    logic [CHAN_W-1:0]   channel;
    logic [DATA7_W-1:0]  note_key;
    logic [DATA7_W-1:0]  note_velocity;
    logic                out_valid;
    logic                out_ready;
    logic [7:0]          out_byte;
    logic                last_byte;

    midi_byte_t pending_bytes[$];
    int         mismatches   = 0;
    int         cycle_count  = 0;
    int         hold_request = 0;
    bit         rx_free_run  = 1'b1;

    midi_note_event_encoder_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .duration_ticks (duration_ticks),
        .channel        (channel),
        .note_key       (note_key),
        .note_velocity  (note_velocity),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .last_byte      (last_byte)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    function automatic void log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endfunction

    function automatic void queue_byte(input logic [7:0] data, input logic last);
        midi_byte_t b;
        b.data = data;
        b.last = last;
        pending_bytes.push_back(b);
    endfunction

    // byte stream of one note event: delta, note-on, duration vlq, note-off
    function automatic void encode_note_event(input logic [DUR_W-1:0]   dur,
                                              input logic [CHAN_W-1:0]  chan,
                                              input logic [DATA7_W-1:0] key,
                                              input logic [DATA7_W-1:0] vel);
        logic [VLQ_W-1:0] ticks;
        int               n_groups;
        ticks = (dur > VLQ_CEILING) ? '1 : dur[VLQ_W-1:0];
        n_groups = 1;
        while (n_groups < 4 && (ticks >> (7 * n_groups)) != '0)
            n_groups++;
        queue_byte(DELTA_ZERO, 1'b0);
        queue_byte({STATUS_NOTE_ON, chan}, 1'b0);
        queue_byte({1'b0, key}, 1'b0);
        queue_byte({1'b0, vel}, 1'b0);
        // most significant group first, continuation bit on all but the last
        for (int g = n_groups - 1; g >= 0; g--)
            queue_byte({(g != 0), ticks[7 * g +: 7]}, 1'b0);
        queue_byte({STATUS_NOTE_OFF, chan}, 1'b0);
        queue_byte({1'b0, key}, 1'b0);
        queue_byte({1'b0, vel}, 1'b1);
    endfunction

    // result checker: outputs are stable between edges, so sample mid-cycle
    // for the byte taken at the coming edge
    initial
    begin
        midi_byte_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_bytes.size() == 0)
                    log_mismatch($sformatf("unexpected byte %02h last %0b", out_byte, last_byte));
                else
                begin
                    want = pending_bytes.pop_front();
                    if (out_byte !== want.data || last_byte !== want.last)
                        log_mismatch($sformatf("byte exp %02h got %02h, last exp %0b got %0b",
                                               want.data, out_byte, want.last, last_byte));
                end
            end
        end
    end

    // receiver: ready runs and stalls, free running, or one long hold
    initial
    begin
        int n;
        forever
        begin
            if (hold_request > 0)
            begin
                n = hold_request;
                hold_request = 0;
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else if (rx_free_run)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
        end
    end

    // offer one item and wait for it to be taken; valid stays high on return
    task automatic offer_event(input logic [DUR_W-1:0]   dur,
                               input logic [CHAN_W-1:0]  chan,
                               input logic [DATA7_W-1:0] key,
                               input logic [DATA7_W-1:0] vel);
        logic taken;
        in_valid       <= 1'b1;
        duration_ticks <= dur;
        channel        <= chan;
        note_key       <= key;
        note_velocity  <= vel;
        // ready seen mid-cycle is the value the coming edge uses
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
        encode_note_event(dur, chan, key, vel);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_all_bytes();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_bytes.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [DUR_W-1:0] random_duration();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return $urandom_range(1, 32'h7F);
            2:       return $urandom_range(32'h80, 32'h3FFF);
            3:       return $urandom_range(32'h4000, 32'h1F_FFFF);
            4:       return $urandom_range(32'h20_0000, 32'h0FFF_FFFF);
            5:       return $urandom_range(32'h1000_0000, 32'hFFFF_FFFF);
            default: return $urandom();
        endcase
    endfunction

    // group boundaries, saturation, zero duration, field extremes
    task automatic test_directed_extremes();
        logic [DUR_W-1:0] durs[13];
        durs = '{32'h0, 32'h1, 32'h7F, 32'h80, 32'h3FFF, 32'h4000, 32'h1F_FFFF,
                 32'h20_0000, 32'h0FFF_FFFF, 32'h1000_0000, 32'hFFFF_FFFF,
                 32'h0AAA_AAAA, 32'h0555_5555};
        rx_free_run = 1'b1;
        for (int i = 0; i < 13; i++)
            offer_event(durs[i], (i % 2) ? 4'hF : 4'h0,
                        (i % 2) ? 7'h7F : 7'h00, (i % 3) ? 7'h00 : 7'h7F);
        idle_sender(3);
    endtask

    // sender stops until every byte has come, then resumes
    task automatic test_pause_and_drain();
        rx_free_run = 1'b0;
        for (int i = 0; i < 3; i++)
            offer_event(random_duration(), $urandom_range(0, 15),
                        $urandom_range(0, 127), $urandom_range(0, 127));
        wait_all_bytes();
        for (int i = 0; i < 3; i++)
            offer_event(random_duration(), $urandom_range(0, 15),
                        $urandom_range(0, 127), $urandom_range(0, 127));
        wait_all_bytes();
    endtask

    // long receiver hold while the sender keeps offering items
    task automatic test_long_stall();
        rx_free_run = 1'b1;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 12; i++)
            offer_event(random_duration(), $urandom_range(0, 15),
                        $urandom_range(0, 127), $urandom_range(0, 127));
        idle_sender(2);
    endtask

    // random events in bursts with random gaps and receiver stalls
    task automatic test_random_events(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 10);
            rx_free_run = ($urandom_range(0, 3) == 0);
            for (int b = 0; b < burst && sent < count; b++)
            begin
                offer_event(random_duration(), $urandom_range(0, 15),
                            $urandom_range(0, 127), $urandom_range(0, 127));
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 30));
        end
    endtask

    // stimulus
    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        duration_ticks <= '0;
        channel        <= '0;
        note_key       <= '0;
        note_velocity  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_pause_and_drain();
        test_long_stall();
        test_random_events(440);

        wait_all_bytes();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_bytes.size() != 0)
            log_mismatch($sformatf("%0d bytes never arrived", pending_bytes.size()));

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
